// ===== design/crth_pkg.sv =====
`timescale 1ns / 1ps
package crth_pkg;

   localparam int MANT_W = 50;

   typedef logic [1:0] fop_type;
   localparam fop_type FOP_ADD = 2'd0;
   localparam fop_type FOP_SUB = 2'd1;
   localparam fop_type FOP_MUL = 2'd2;
   localparam fop_type FOP_DIV = 2'd3;

   localparam logic [31:0] FP_QNAN_DEFAULT = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT    = 32'h0040_0000;
   localparam logic [31:0] FP_ZERO         = 32'h0000_0000;

   localparam logic [5:0] AXIS_RESET = 6'h24;

   function automatic logic f_nan(input logic [31:0] a);
      return (&a[30:23]) && (|a[22:0]);
   endfunction

   function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
      if (f_nan(a) || f_nan(b)) return 1'b0;
      return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
   endfunction

   function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
      if (f_nan(a) || f_nan(b)) return 1'b0;
      if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
      if (a[31] != b[31]) return a[31];
      if (!a[31]) return a[30:0] < b[30:0];
      return a[30:0] > b[30:0];
   endfunction

   function automatic logic f_le(input logic [31:0] a, input logic [31:0] b);
      return f_lt(a, b) || f_eq(a, b);
   endfunction

   // axis code three falls back to z
   function automatic logic [1:0] axis_sel(input logic [1:0] code);
      return (code == 2'd3) ? 2'd2 : code;
   endfunction

   function automatic logic [31:0] pick3(input logic [1:0] k, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
      case (k)
         2'd0: return x;
         2'd1: return y;
         default: return z;
      endcase
   endfunction

endpackage

// ===== design/crth_fpu.sv =====
`timescale 1ns / 1ps
module crth_fpu
   import crth_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  fop_type     op,
   input  logic [31:0] opa,
   input  logic [31:0] opb,
   output logic        done,
   output logic [31:0] result
);

   localparam logic [3:0] FS_IDLE   = 4'd0;
   localparam logic [3:0] FS_PREP   = 4'd1;
   localparam logic [3:0] FS_NA     = 4'd2;
   localparam logic [3:0] FS_NB     = 4'd3;
   localparam logic [3:0] FS_DIV    = 4'd4;
   localparam logic [3:0] FS_NORM   = 4'd5;
   localparam logic [3:0] FS_DENORM = 4'd6;
   localparam logic [3:0] FS_ROUND  = 4'd7;

   logic [3:0]          st_ff;
   fop_type             op_ff;
   logic [31:0]         a_ff, b_ff;
   logic                sgn_ff;
   logic [MANT_W-1:0]   m_ff;
   logic signed [10:0]  x_ff;
   logic [23:0]         da_ff, db_ff;
   logic [24:0]         rem_ff;
   logic [25:0]         q_ff;
   logic [4:0]          cnt_ff;
   logic [31:0]         res_ff;
   logic                done_ff;

   // operand decode
   logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sb_eff, ps;
   logic [23:0]        ma, mb;
   logic [7:0]         ea, eb;
   logic signed [10:0] exa, exb;
   logic               spec;
   logic [31:0]        spec_res;
   // add path
   logic               a_big, big_s;
   logic [23:0]        big_m, sm_m;
   logic [7:0]         big_e, sm_e, dsh;
   logic [MANT_W-1:0]  wide_b, wide_s, shr_s, al_s, sum_m;
   logic               add_sgn;
   // multiply
   logic [47:0]        prod;
   // divide step
   logic               ge;
   logic [24:0]        rem_sub, rem_nx;
   logic [25:0]        q_nx;
   // denormal shift and rounding
   logic signed [10:0] sh;
   logic [MANT_W-1:0]  den_m;
   logic [23:0]        rmant;
   logic               rup;
   logic [30:0]        rmag;

   always_comb begin
      nan_a  = f_nan(a_ff);
      nan_b  = f_nan(b_ff);
      inf_a  = (&a_ff[30:23]) && (a_ff[22:0] == 23'd0);
      inf_b  = (&b_ff[30:23]) && (b_ff[22:0] == 23'd0);
      zero_a = a_ff[30:0] == 31'd0;
      zero_b = b_ff[30:0] == 31'd0;
      sb_eff = b_ff[31] ^ (op_ff == FOP_SUB);
      ps     = a_ff[31] ^ b_ff[31];
      ma     = {a_ff[30:23] != 8'd0, a_ff[22:0]};
      mb     = {b_ff[30:23] != 8'd0, b_ff[22:0]};
      ea     = (a_ff[30:23] == 8'd0) ? 8'd1 : a_ff[30:23];
      eb     = (b_ff[30:23] == 8'd0) ? 8'd1 : b_ff[30:23];
      exa    = $signed({3'b000, ea});
      exb    = $signed({3'b000, eb});
      prod   = ma * mb;

      spec     = 1'b1;
      spec_res = FP_QNAN_DEFAULT;
      if (nan_a) begin
         spec_res = a_ff | FP_QUIET_BIT;
      end else if (nan_b) begin
         spec_res = b_ff | FP_QUIET_BIT;
      end else begin
         case (op_ff)
            FOP_ADD, FOP_SUB: begin
               if (inf_a && inf_b && (a_ff[31] != sb_eff)) spec_res = FP_QNAN_DEFAULT;
               else if (inf_a) spec_res = a_ff;
               else if (inf_b) spec_res = {sb_eff, b_ff[30:0]};
               else spec = 1'b0;
            end
            FOP_MUL: begin
               if ((inf_a && zero_b) || (zero_a && inf_b)) spec_res = FP_QNAN_DEFAULT;
               else if (inf_a || inf_b) spec_res = {ps, 8'hFF, 23'd0};
               else if (zero_a || zero_b) spec_res = {ps, 31'd0};
               else spec = 1'b0;
            end
            default: begin
               if ((inf_a && inf_b) || (zero_a && zero_b)) spec_res = FP_QNAN_DEFAULT;
               else if (inf_a || zero_b) spec_res = {ps, 8'hFF, 23'd0};
               else if (inf_b || zero_a) spec_res = {ps, 31'd0};
               else spec = 1'b0;
            end
         endcase
      end

      // align the smaller magnitude, keep shifted-out bits as sticky
      a_big  = a_ff[30:0] >= b_ff[30:0];
      big_m  = a_big ? ma : mb;
      sm_m   = a_big ? mb : ma;
      big_e  = a_big ? ea : eb;
      sm_e   = a_big ? eb : ea;
      big_s  = a_big ? a_ff[31] : sb_eff;
      dsh    = big_e - sm_e;
      wide_b = {1'b0, big_m, 25'd0};
      wide_s = {1'b0, sm_m, 25'd0};
      shr_s  = wide_s >> dsh;
      al_s   = shr_s | {{(MANT_W-1){1'b0}}, (shr_s << dsh) != wide_s};
      if (a_ff[31] == sb_eff) sum_m = wide_b + al_s;
      else sum_m = wide_b - al_s;
      add_sgn = (sum_m == '0) ? (a_ff[31] & sb_eff) : big_s;

      ge      = rem_ff >= {1'b0, db_ff};
      rem_sub = ge ? (rem_ff - {1'b0, db_ff}) : rem_ff;
      rem_nx  = {rem_sub[23:0], 1'b0};
      q_nx    = {q_ff[24:0], ge};

      sh = 11'sd1 - x_ff;
      if (sh >= 11'sd50) den_m = {{(MANT_W-1){1'b0}}, m_ff != '0};
      else den_m = (m_ff >> sh[5:0])
                   | {{(MANT_W-1){1'b0}}, ((m_ff >> sh[5:0]) << sh[5:0]) != m_ff};

      rmant = m_ff[MANT_W-1:MANT_W-24];
      rup   = m_ff[MANT_W-25] && ((|m_ff[MANT_W-26:0]) || rmant[0]);
      rmag  = {x_ff[7:0] - 8'd1, 23'd0} + {7'd0, rmant} + {30'd0, rup};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= FS_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            FS_IDLE: begin
               if (start) begin
                  op_ff <= op;
                  a_ff  <= opa;
                  b_ff  <= opb;
                  st_ff <= FS_PREP;
               end
            end
            FS_PREP: begin
               if (spec) begin
                  res_ff  <= spec_res;
                  done_ff <= 1'b1;
                  st_ff   <= FS_IDLE;
               end else begin
                  case (op_ff)
                     FOP_ADD, FOP_SUB: begin
                        sgn_ff <= add_sgn;
                        m_ff   <= sum_m;
                        x_ff   <= $signed({3'b000, big_e}) + 11'sd1;
                        st_ff  <= FS_NORM;
                     end
                     FOP_MUL: begin
                        sgn_ff <= ps;
                        m_ff   <= {prod, 2'b00};
                        x_ff   <= exa + exb - 11'sd126;
                        st_ff  <= FS_NORM;
                     end
                     default: begin
                        sgn_ff <= ps;
                        da_ff  <= ma;
                        db_ff  <= mb;
                        x_ff   <= exa - exb + 11'sd127;
                        st_ff  <= FS_NA;
                     end
                  endcase
               end
            end
            FS_NA: begin
               if (da_ff[23]) begin
                  st_ff <= FS_NB;
               end else if (da_ff[23:16] == 8'd0) begin
                  da_ff <= {da_ff[15:0], 8'd0};
                  x_ff  <= x_ff - 11'sd8;
               end else begin
                  da_ff <= {da_ff[22:0], 1'b0};
                  x_ff  <= x_ff - 11'sd1;
               end
            end
            FS_NB: begin
               if (db_ff[23]) begin
                  rem_ff <= {1'b0, da_ff};
                  cnt_ff <= 5'd0;
                  st_ff  <= FS_DIV;
               end else if (db_ff[23:16] == 8'd0) begin
                  db_ff <= {db_ff[15:0], 8'd0};
                  x_ff  <= x_ff + 11'sd8;
               end else begin
                  db_ff <= {db_ff[22:0], 1'b0};
                  x_ff  <= x_ff + 11'sd1;
               end
            end
            FS_DIV: begin
               q_ff   <= q_nx;
               rem_ff <= rem_nx;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd25) begin
                  m_ff  <= {q_nx, rem_nx != 25'd0, 23'd0};
                  st_ff <= FS_NORM;
               end
            end
            FS_NORM: begin
               if (m_ff == '0) begin
                  res_ff  <= {sgn_ff, 31'd0};
                  done_ff <= 1'b1;
                  st_ff   <= FS_IDLE;
               end else if (m_ff[MANT_W-1]) begin
                  st_ff <= FS_DENORM;
               end else if (m_ff[MANT_W-1:MANT_W-8] == 8'd0) begin
                  m_ff <= {m_ff[MANT_W-9:0], 8'd0};
                  x_ff <= x_ff - 11'sd8;
               end else begin
                  m_ff <= {m_ff[MANT_W-2:0], 1'b0};
                  x_ff <= x_ff - 11'sd1;
               end
            end
            FS_DENORM: begin
               if (x_ff <= 11'sd0) begin
                  m_ff <= den_m;
                  x_ff <= 11'sd1;
               end
               st_ff <= FS_ROUND;
            end
            FS_ROUND: begin
               if (x_ff >= 11'sd255) res_ff <= {sgn_ff, 8'hFF, 23'd0};
               else res_ff <= {sgn_ff, rmag};
               done_ff <= 1'b1;
               st_ff   <= FS_IDLE;
            end
            default: st_ff <= FS_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== design/closest_ray_triangle_hit.sv =====
`timescale 1ns / 1ps
// Closest-hit ray/triangle tester, IEEE single precision.
// Input stream (req_): tuser = action (0 begin ray, 1 test face), tlast = last
// face of the ray, tdata = first/second/third vertex words and the tag.
// A begin beat loads origin, shear, axis order and depth limit and clears the
// kept hit; its response is registered once the output register is free.
// A face beat runs 42 float operations, one after another, through a single
// shared add/multiply/divide unit. An add or multiply passes through prepare,
// normalize shift steps, denormal and round; an infinite or NaN operand, or a
// zero one to a multiply or divide, ends after prepare. The divide normalizes
// both mantissas, forms the quotient bit by bit, then normalizes and rounds. A
// mixed-sign reject ends after 31 operations, a zero determinant after 32. One
// item is worked on at a time; req_tready is high only while the block is idle.
// Every input beat yields one response beat (rsp_): tdata holds hit_found,
// hit_depth and hit_face of the closest hit so far, tlast echoes the input
// tlast. The response sits in an output register; a stalled receiver holds it
// there, and the next finished item waits in the output step until it is free.
// Reset: ray and kept hit go to zero, axis order to x,y,z, no response pending.
module closest_ray_triangle_hit
   import crth_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // third_x, third_y, third_z, tag
   input  logic [311:0] req_tdata,
   input  logic         req_tuser,   // action
   input  logic         req_tlast,   // last_face
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // hit_found, hit_depth, hit_face, zero pad
   output logic         rsp_tlast    // run_done
);

   localparam logic [4:0] P_IDLE  = 5'd0;
   localparam logic [4:0] P_TZ    = 5'd1;
   localparam logic [4:0] P_TX    = 5'd2;
   localparam logic [4:0] P_TY    = 5'd3;
   localparam logic [4:0] P_MX    = 5'd4;
   localparam logic [4:0] P_AX    = 5'd5;
   localparam logic [4:0] P_MY    = 5'd6;
   localparam logic [4:0] P_AY    = 5'd7;
   localparam logic [4:0] P_EM0   = 5'd8;
   localparam logic [4:0] P_EM1   = 5'd9;
   localparam logic [4:0] P_ESUB  = 5'd10;
   localparam logic [4:0] P_DET01 = 5'd11;
   localparam logic [4:0] P_DET   = 5'd12;
   localparam logic [4:0] P_ZS    = 5'd13;
   localparam logic [4:0] P_D     = 5'd14;
   localparam logic [4:0] P_T01   = 5'd15;
   localparam logic [4:0] P_T     = 5'd16;
   localparam logic [4:0] P_BND   = 5'd17;
   localparam logic [4:0] P_DIV   = 5'd18;
   localparam logic [4:0] P_OUT   = 5'd19;

   logic [4:0]  phase_ff;
   logic [1:0]  vi_ff;
   logic        wait_ff;
   logic [31:0] v0x_ff, v0y_ff, v0z_ff, v1x_ff, v1y_ff, v1z_ff, v2x_ff, v2y_ff, v2z_ff;
   logic [23:0] tag_ff;
   logic        last_ff;
   logic [31:0] tax_ff, tay_ff, taz_ff, tbx_ff, tby_ff, tbz_ff, tcx_ff, tcy_ff, tcz_ff;
   logic [31:0] tmp_ff, m0_ff, e0_ff, e1_ff, e2_ff, det_ff, d0_ff, d1_ff, d2_ff, ts_ff;
   logic [31:0] org_x_ff, org_y_ff, org_z_ff, shr_x_ff, shr_y_ff, shr_z_ff;
   logic [5:0]  axis_ff;
   logic [31:0] limit_ff, best_depth_ff;
   logic [23:0] best_face_ff;
   logic        any_hit_ff;
   logic        rsp_valid_ff, rsp_last_ff;
   logic [63:0] rsp_data_ff;

   logic        in_beat, out_free, computing, fpu_start, fpu_done;
   fop_type     fpu_op;
   logic [31:0] fpu_a, fpu_b, fpu_res;
   logic [1:0]  kx, ky, kz, pi, qi;
   logic [31:0] vx, vy, vz, xcur, ycur, zcur, ecur;
   logic        mixed, reject;

   assign in_beat   = req_tvalid && req_tready;
   assign req_tready = phase_ff == P_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign computing = (phase_ff != P_IDLE) && (phase_ff != P_OUT);
   assign fpu_start = computing && !wait_ff;

   always_comb begin
      kx   = axis_sel(axis_ff[1:0]);
      ky   = axis_sel(axis_ff[3:2]);
      kz   = axis_sel(axis_ff[5:4]);
      pi   = (vi_ff == 2'd2) ? 2'd0 : vi_ff + 2'd1;
      qi   = (vi_ff == 2'd0) ? 2'd2 : vi_ff - 2'd1;
      vx   = pick3(vi_ff, v0x_ff, v1x_ff, v2x_ff);
      vy   = pick3(vi_ff, v0y_ff, v1y_ff, v2y_ff);
      vz   = pick3(vi_ff, v0z_ff, v1z_ff, v2z_ff);
      xcur = pick3(vi_ff, tax_ff, tbx_ff, tcx_ff);
      ycur = pick3(vi_ff, tay_ff, tby_ff, tcy_ff);
      zcur = pick3(vi_ff, taz_ff, tbz_ff, tcz_ff);
      ecur = pick3(vi_ff, e0_ff, e1_ff, e2_ff);

      fpu_op = FOP_ADD;
      fpu_a  = ts_ff;
      fpu_b  = d2_ff;
      case (phase_ff)
         P_TZ: begin
            fpu_op = FOP_SUB;
            fpu_a  = pick3(kz, vx, vy, vz);
            fpu_b  = pick3(kz, org_x_ff, org_y_ff, org_z_ff);
         end
         P_TX: begin
            fpu_op = FOP_SUB;
            fpu_a  = pick3(kx, vx, vy, vz);
            fpu_b  = pick3(kx, org_x_ff, org_y_ff, org_z_ff);
         end
         P_TY: begin
            fpu_op = FOP_SUB;
            fpu_a  = pick3(ky, vx, vy, vz);
            fpu_b  = pick3(ky, org_x_ff, org_y_ff, org_z_ff);
         end
         P_MX: begin fpu_op = FOP_MUL; fpu_a = shr_x_ff; fpu_b = zcur; end
         P_AX: begin fpu_a = xcur; fpu_b = tmp_ff; end
         P_MY: begin fpu_op = FOP_MUL; fpu_a = shr_y_ff; fpu_b = zcur; end
         P_AY: begin fpu_a = ycur; fpu_b = tmp_ff; end
         P_EM0: begin
            fpu_op = FOP_MUL;
            fpu_a  = pick3(pi, tax_ff, tbx_ff, tcx_ff);
            fpu_b  = pick3(qi, tay_ff, tby_ff, tcy_ff);
         end
         P_EM1: begin
            fpu_op = FOP_MUL;
            fpu_a  = pick3(pi, tay_ff, tby_ff, tcy_ff);
            fpu_b  = pick3(qi, tax_ff, tbx_ff, tcx_ff);
         end
         P_ESUB:  begin fpu_op = FOP_SUB; fpu_a = m0_ff; fpu_b = tmp_ff; end
         P_DET01: begin fpu_a = e0_ff; fpu_b = e1_ff; end
         P_DET:   begin fpu_a = det_ff; fpu_b = e2_ff; end
         P_ZS:    begin fpu_op = FOP_MUL; fpu_a = zcur; fpu_b = shr_z_ff; end
         P_D:     begin fpu_op = FOP_MUL; fpu_a = ecur; fpu_b = tmp_ff; end
         P_T01:   begin fpu_a = d0_ff; fpu_b = d1_ff; end
         P_T:     begin fpu_a = ts_ff; fpu_b = d2_ff; end
         P_BND:   begin fpu_op = FOP_MUL; fpu_a = limit_ff; fpu_b = det_ff; end
         P_DIV:   begin fpu_op = FOP_DIV; fpu_a = ts_ff; fpu_b = det_ff; end
         default: begin fpu_op = FOP_ADD; end
      endcase

      mixed = (f_lt(e0_ff, FP_ZERO) || f_lt(e1_ff, FP_ZERO) || f_lt(e2_ff, FP_ZERO))
              && (f_lt(FP_ZERO, e0_ff) || f_lt(FP_ZERO, e1_ff) || f_lt(FP_ZERO, e2_ff));
      // fpu_res is the bound when this is used
      reject = (f_lt(det_ff, FP_ZERO) && (f_le(FP_ZERO, ts_ff) || f_lt(ts_ff, fpu_res)))
               || (f_lt(FP_ZERO, det_ff) && (f_le(ts_ff, FP_ZERO) || f_lt(fpu_res, ts_ff)));
   end

   crth_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (fpu_start),
      .op     (fpu_op),
      .opa    (fpu_a),
      .opb    (fpu_b),
      .done   (fpu_done),
      .result (fpu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= P_IDLE;
         vi_ff         <= 2'd0;
         wait_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         org_x_ff      <= FP_ZERO;
         org_y_ff      <= FP_ZERO;
         org_z_ff      <= FP_ZERO;
         shr_x_ff      <= FP_ZERO;
         shr_y_ff      <= FP_ZERO;
         shr_z_ff      <= FP_ZERO;
         axis_ff       <= AXIS_RESET;
         limit_ff      <= FP_ZERO;
         any_hit_ff    <= 1'b0;
         best_depth_ff <= FP_ZERO;
         best_face_ff  <= 24'd0;
      end else begin
         // the output step reloads the register itself
         if (rsp_valid_ff && rsp_tready && (phase_ff != P_OUT)) rsp_valid_ff <= 1'b0;
         if (fpu_start) wait_ff <= 1'b1;

         if (in_beat) begin
            last_ff <= req_tlast;
            tag_ff  <= req_tdata[311:288];
            if (!req_tuser) begin
               org_x_ff      <= req_tdata[31:0];
               org_y_ff      <= req_tdata[63:32];
               org_z_ff      <= req_tdata[95:64];
               shr_x_ff      <= req_tdata[127:96];
               shr_y_ff      <= req_tdata[159:128];
               shr_z_ff      <= req_tdata[191:160];
               limit_ff      <= req_tdata[223:192];
               axis_ff       <= req_tdata[293:288];
               any_hit_ff    <= 1'b0;
               best_depth_ff <= FP_ZERO;
               best_face_ff  <= 24'd0;
               phase_ff      <= P_OUT;
            end else begin
               v0x_ff   <= req_tdata[31:0];
               v0y_ff   <= req_tdata[63:32];
               v0z_ff   <= req_tdata[95:64];
               v1x_ff   <= req_tdata[127:96];
               v1y_ff   <= req_tdata[159:128];
               v1z_ff   <= req_tdata[191:160];
               v2x_ff   <= req_tdata[223:192];
               v2y_ff   <= req_tdata[255:224];
               v2z_ff   <= req_tdata[287:256];
               vi_ff    <= 2'd0;
               phase_ff <= P_TZ;
            end
         end else if (phase_ff == P_OUT) begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
               rsp_last_ff  <= last_ff;
               rsp_data_ff  <= {7'd0, best_face_ff, best_depth_ff, any_hit_ff};
               phase_ff     <= P_IDLE;
            end
         end else if (fpu_done) begin
            wait_ff <= 1'b0;
            case (phase_ff)
               P_TZ: begin
                  case (vi_ff)
                     2'd0: taz_ff <= fpu_res;
                     2'd1: tbz_ff <= fpu_res;
                     default: tcz_ff <= fpu_res;
                  endcase
                  phase_ff <= P_TX;
               end
               P_TX, P_AX: begin
                  case (vi_ff)
                     2'd0: tax_ff <= fpu_res;
                     2'd1: tbx_ff <= fpu_res;
                     default: tcx_ff <= fpu_res;
                  endcase
                  phase_ff <= (phase_ff == P_TX) ? P_TY : P_MY;
               end
               P_TY, P_AY: begin
                  case (vi_ff)
                     2'd0: tay_ff <= fpu_res;
                     2'd1: tby_ff <= fpu_res;
                     default: tcy_ff <= fpu_res;
                  endcase
                  if (phase_ff == P_TY) begin
                     phase_ff <= P_MX;
                  end else if (vi_ff == 2'd2) begin
                     vi_ff    <= 2'd0;
                     phase_ff <= P_EM0;
                  end else begin
                     vi_ff    <= vi_ff + 2'd1;
                     phase_ff <= P_TZ;
                  end
               end
               P_MX: begin tmp_ff <= fpu_res; phase_ff <= P_AX; end
               P_MY: begin tmp_ff <= fpu_res; phase_ff <= P_AY; end
               P_EM0: begin m0_ff <= fpu_res; phase_ff <= P_EM1; end
               P_EM1: begin tmp_ff <= fpu_res; phase_ff <= P_ESUB; end
               P_ESUB: begin
                  case (vi_ff)
                     2'd0: e0_ff <= fpu_res;
                     2'd1: e1_ff <= fpu_res;
                     default: e2_ff <= fpu_res;
                  endcase
                  if (vi_ff == 2'd2) begin
                     vi_ff    <= 2'd0;
                     phase_ff <= P_DET01;
                  end else begin
                     vi_ff    <= vi_ff + 2'd1;
                     phase_ff <= P_EM0;
                  end
               end
               P_DET01: begin
                  det_ff   <= fpu_res;
                  phase_ff <= mixed ? P_OUT : P_DET;
               end
               P_DET: begin
                  det_ff   <= fpu_res;
                  phase_ff <= f_eq(fpu_res, FP_ZERO) ? P_OUT : P_ZS;
               end
               P_ZS: begin tmp_ff <= fpu_res; phase_ff <= P_D; end
               P_D: begin
                  case (vi_ff)
                     2'd0: d0_ff <= fpu_res;
                     2'd1: d1_ff <= fpu_res;
                     default: d2_ff <= fpu_res;
                  endcase
                  if (vi_ff == 2'd2) begin
                     vi_ff    <= 2'd0;
                     phase_ff <= P_T01;
                  end else begin
                     vi_ff    <= vi_ff + 2'd1;
                     phase_ff <= P_ZS;
                  end
               end
               P_T01: begin ts_ff <= fpu_res; phase_ff <= P_T; end
               P_T:   begin ts_ff <= fpu_res; phase_ff <= P_BND; end
               P_BND: phase_ff <= reject ? P_OUT : P_DIV;
               P_DIV: begin
                  best_depth_ff <= fpu_res;
                  limit_ff      <= fpu_res;
                  best_face_ff  <= tag_ff;
                  any_hit_ff    <= 1'b1;
                  phase_ff      <= P_OUT;
               end
               default: phase_ff <= P_IDLE;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      in_beat |=> !req_tready)
      else $error("input taken while an item is in progress");

   a_done_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      fpu_done |-> (wait_ff && computing))
      else $error("float unit result with no operation outstanding");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(phase_ff == P_OUT))
      else $error("response raised outside the output step");

   a_clear_hit: assert property (@(posedge clock) disable iff (reset)
      !any_hit_ff |-> (best_depth_ff == FP_ZERO && best_face_ff == 24'd0))
      else $error("kept hit not cleared while no hit recorded");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import crth_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_HOLD      = 3000;

   typedef struct {
      bit          action;
      bit [31:0]   w[9];
      bit [23:0]   tag;
      bit          last;
   } beat_type;

   typedef struct {
      bit          hit;
      bit [31:0]   depth;
      bit [23:0]   face;
      bit          done;
   } hit_rec_type;

   // single-precision arithmetic carried out in double, then rounded once
   function automatic real f32_to_real(bit [31:0] b);
      real r;
      if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
      if (b[30:0] == 31'd0) return $bitstoreal({b[31], 63'd0});
      if (b[30:23] == 8'd0) begin
         r = b[22:0];
         r = r / (2.0 ** 149);
         return b[31] ? -r : r;
      end
      return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'd0});
   endfunction

   function automatic bit [31:0] real_to_f32(real r);
      bit [63:0] d, sig, kept, rest, half;
      bit        s;
      int        ex, sh;
      d = $realtobits(r);
      s = d[63];
      if (d[62:52] == 11'h7FF)
         return (d[51:0] != 52'd0) ? {s, 8'hFF, 1'b1, d[50:29]} : {s, 8'hFF, 23'd0};
      if (d[62:52] == 11'd0) return {s, 31'd0};
      ex = int'(d[62:52]) - 1023;
      sig = {11'd0, 1'b1, d[51:0]};
      sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
      if (sh > 60) return {s, 31'd0};
      kept = sig >> sh;
      rest = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rest > half || (rest == half && kept[0])) kept = kept + 64'd1;
      if (ex >= -126) begin
         if (kept[24]) begin
            kept = kept >> 1;
            ex++;
         end
         if (ex + 127 >= 255) return {s, 8'hFF, 23'd0};
         return {s, 8'(ex + 127), kept[22:0]};
      end
      return {s, kept[30:0]};
   endfunction

   function automatic bit is_nan(bit [31:0] a);
      return (&a[30:23]) && (|a[22:0]);
   endfunction

   function automatic bit [31:0] fop(fop_type op, bit [31:0] a, bit [31:0] b);
      real ra, rb, rr;
      if (is_nan(a)) return a | FP_QUIET_BIT;
      if (is_nan(b)) return b | FP_QUIET_BIT;
      ra = f32_to_real(a);
      rb = f32_to_real(b);
      case (op)
         FOP_ADD: rr = ra + rb;
         FOP_SUB: rr = ra - rb;
         FOP_MUL: rr = ra * rb;
         default: rr = ra / rb;
      endcase
      if (rr != rr) return FP_QNAN_DEFAULT;
      return real_to_f32(rr);
   endfunction

   function automatic bit flt(bit [31:0] a, bit [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return f32_to_real(a) < f32_to_real(b);
   endfunction

   function automatic bit feq(bit [31:0] a, bit [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return f32_to_real(a) == f32_to_real(b);
   endfunction

   class hit_scoreboard;
      bit [31:0]   origin[3];
      bit [31:0]   shear[3];
      bit [5:0]    axes;
      bit [31:0]   limit;
      bit          any_hit;
      bit [31:0]   best_depth;
      bit [23:0]   best_face;
      hit_rec_type pending[$];
      int          errors;

      function new();
         origin = '{32'd0, 32'd0, 32'd0};
         shear = '{32'd0, 32'd0, 32'd0};
         axes = AXIS_RESET;
         limit = '0;
         any_hit = 1'b0;
         best_depth = '0;
         best_face = '0;
         errors = 0;
      endfunction

      function int sel(bit [1:0] code);
         return (code == 2'd3) ? 2 : int'(code);
      endfunction

      // move to origin, permute, shear x and y by z
      function void place(bit [31:0] x, bit [31:0] y, bit [31:0] z,
                          output bit [31:0] px, output bit [31:0] py,
                          output bit [31:0] pz);
         bit [31:0] t[3];
         t[0] = fop(FOP_SUB, x, origin[0]);
         t[1] = fop(FOP_SUB, y, origin[1]);
         t[2] = fop(FOP_SUB, z, origin[2]);
         pz = t[sel(axes[5:4])];
         px = fop(FOP_ADD, t[sel(axes[1:0])], fop(FOP_MUL, shear[0], pz));
         py = fop(FOP_ADD, t[sel(axes[3:2])], fop(FOP_MUL, shear[1], pz));
      endfunction

      function void note_item(beat_type b);
         bit [31:0]   ax, ay, az, bx, by, bz, cx, cy, cz;
         bit [31:0]   e0, e1, e2, det, tsc, bound, z;
         bit          hit, neg, pos;
         hit_rec_type r;
         z = 32'd0;
         if (!b.action) begin
            origin = '{b.w[0], b.w[1], b.w[2]};
            shear = '{b.w[3], b.w[4], b.w[5]};
            limit = b.w[6];
            axes = b.tag[5:0];
            any_hit = 1'b0;
            best_depth = '0;
            best_face = '0;
         end else begin
            place(b.w[0], b.w[1], b.w[2], ax, ay, az);
            place(b.w[3], b.w[4], b.w[5], bx, by, bz);
            place(b.w[6], b.w[7], b.w[8], cx, cy, cz);
            e0 = fop(FOP_SUB, fop(FOP_MUL, bx, cy), fop(FOP_MUL, by, cx));
            e1 = fop(FOP_SUB, fop(FOP_MUL, cx, ay), fop(FOP_MUL, cy, ax));
            e2 = fop(FOP_SUB, fop(FOP_MUL, ax, by), fop(FOP_MUL, ay, bx));
            neg = flt(e0, z) || flt(e1, z) || flt(e2, z);
            pos = flt(z, e0) || flt(z, e1) || flt(z, e2);
            hit = !(neg && pos);
            det = fop(FOP_ADD, fop(FOP_ADD, e0, e1), e2);
            if (hit && feq(det, z)) hit = 0;
            if (hit) begin
               tsc = fop(FOP_ADD,
                         fop(FOP_ADD, fop(FOP_MUL, e0, fop(FOP_MUL, az, shear[2])),
                                      fop(FOP_MUL, e1, fop(FOP_MUL, bz, shear[2]))),
                         fop(FOP_MUL, e2, fop(FOP_MUL, cz, shear[2])));
               bound = fop(FOP_MUL, limit, det);
               // a NaN depth passes both ordered tests
               if (flt(det, z) && (flt(z, tsc) || feq(tsc, z) || flt(tsc, bound)))
                  hit = 0;
               else if (flt(z, det) && (flt(tsc, z) || feq(tsc, z) || flt(bound, tsc)))
                  hit = 0;
               if (hit) begin
                  best_depth = fop(FOP_DIV, tsc, det);
                  best_face = b.tag;
                  limit = best_depth;
                  any_hit = 1;
               end
            end
         end
         r.hit = any_hit;
         r.depth = best_depth;
         r.face = best_face;
         r.done = b.last;
         pending.push_back(r);
      endfunction

      function void check_result(bit [63:0] data, bit done);
         hit_rec_type r;
         if (pending.size() == 0) begin
            $error("response beat with nothing expected: tdata %h", data);
            errors++;
            return;
         end
         r = pending.pop_front();
         if (data[0] !== r.hit) begin
            $error("hit_found: expected %0d, got %0d", r.hit, data[0]);
            errors++;
         end
         if (data[32:1] !== r.depth) begin
            $error("hit_depth: expected %h, got %h", r.depth, data[32:1]);
            errors++;
         end
         if (data[56:33] !== r.face) begin
            $error("hit_face: expected %h, got %h", r.face, data[56:33]);
            errors++;
         end
         if (done !== r.done) begin
            $error("run_done: expected %0d, got %0d", r.done, done);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [311:0] req_tdata = '0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;

   hit_scoreboard sb = new();
   beat_type      stim[$];
   bit            hold_request = 0;
   int            idle_cycles = 0;

   closest_ray_triangle_hit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic real rnd(real lo, real hi);
      return lo + (hi - lo) * ($urandom / 4294967295.0);
   endfunction

   function automatic bit [31:0] f(real r);
      return real_to_f32(r);
   endfunction

   function automatic void add_ray(real o[3], real s[3], bit [31:0] lim,
                                   bit [23:0] tag, bit last);
      beat_type b;
      b.action = 0;
      for (int i = 0; i < 3; i++) begin
         b.w[i] = f(o[i]);
         b.w[3 + i] = f(s[i]);
      end
      b.w[6] = lim;
      b.w[7] = $urandom;
      b.w[8] = $urandom;
      b.tag = tag;
      b.last = last;
      stim.push_back(b);
   endfunction

   function automatic void add_face(real v[9], bit [23:0] tag, bit last);
      beat_type b;
      b.action = 1;
      foreach (v[i]) b.w[i] = f(v[i]);
      b.tag = tag;
      b.last = last;
      stim.push_back(b);
   endfunction

   function automatic void add_raw(bit action, bit [31:0] word, bit [23:0] tag, bit last);
      beat_type b;
      b.action = action;
      foreach (b.w[i]) b.w[i] = word;
      b.tag = tag;
      b.last = last;
      stim.push_back(b);
   endfunction

   task automatic build_directed();
      real zero3[3] = '{0.0, 0.0, 0.0};
      real up[3] = '{0.0, 0.0, 1.0};
      real down[3] = '{0.0, 0.0, -1.0};
      beat_type b;
      // face ahead of any ray: reset ray, limit zero
      add_face('{-1.0, -1.0, 5.0, 1.0, -1.0, 5.0, 0.0, 1.0, 5.0}, 24'h000001, 0);
      add_raw(0, 32'h0000_0000, 24'h000000, 1);
      add_raw(0, 32'hFFFF_FFFF, 24'hFFFFFF, 1);
      add_raw(1, 32'hFFFF_FFFF, 24'hFFFFFF, 1);
      add_ray(zero3, up, 32'h7F80_0000, {18'd0, 6'h24}, 0);
      add_face('{-1.0, -1.0, 5.0, 1.0, -1.0, 5.0, 0.0, 1.0, 5.0}, 24'h000007, 0);
      // equal depth, later face must win
      add_face('{-1.0, -1.0, 5.0, 0.0, 1.0, 5.0, 1.0, -1.0, 5.0}, 24'h000009, 0);
      add_face('{-1.0, -1.0, 2.0, 1.0, -1.0, 2.0, 0.0, 1.0, 2.0}, 24'h000003, 0);
      add_face('{-1.0, -1.0, 9.0, 1.0, -1.0, 9.0, 0.0, 1.0, 9.0}, 24'h000004, 0);
      add_face('{1.0, 1.0, 1.0, 1.0, 1.0, 1.0, 1.0, 1.0, 1.0}, 24'h000005, 0);
      add_face('{3.0, 3.0, 1.0, 4.0, 3.0, 1.0, 3.0, 4.0, 1.0}, 24'h000006, 0);
      b = stim[$];
      b.w[4] = 32'h7FC1_2345;
      b.tag = 24'h800000;
      stim.push_back(b);
      b.w[4] = 32'hFF80_0000;
      b.last = 1;
      stim.push_back(b);
      // axis code three, high tag bits ignored
      add_ray('{0.5, -0.5, 0.25}, '{0.1, -0.2, 1.0}, f(100.0), 24'hABCD00 | 24'h23, 0);
      add_face('{-2.0, -2.0, 4.0, 2.0, -2.0, 4.0, 0.0, 2.0, 4.0}, 24'h00FFFF, 1);
      add_ray(zero3, up, 32'h0000_0000, 24'h000024, 0);
      add_face('{-1.0, -1.0, 5.0, 1.0, -1.0, 5.0, 0.0, 1.0, 5.0}, 24'h000011, 1);
      add_ray(zero3, down, f(50.0), 24'h000024, 0);
      add_face('{-1.0, -1.0, -5.0, 1.0, -1.0, -5.0, 0.0, 1.0, -5.0}, 24'h000012, 0);
      add_face('{-1.0, -1.0, 5.0, 1.0, -1.0, 5.0, 0.0, 1.0, 5.0}, 24'h000013, 1);
   endtask

   task automatic build_random(int target);
      real       o[3], s[3], v[9];
      bit [5:0]  ax;
      bit [31:0] lim;
      int        kz, nf, pick;
      real       zs;
      beat_type  b;
      while (stim.size() < target) begin
         if ($urandom_range(0, 9) == 0) begin
            b.action = 1'($urandom);
            foreach (b.w[i]) b.w[i] = $urandom;
            b.tag = 24'($urandom);
            b.last = 1'($urandom);
            stim.push_back(b);
            continue;
         end
         kz = $urandom_range(0, 2);
         ax = {2'(kz), 2'((kz + 2) % 3), 2'((kz + 1) % 3)};
         if ($urandom_range(0, 7) == 0) ax = 6'($urandom);
         for (int i = 0; i < 3; i++) o[i] = rnd(-4.0, 4.0);
         s[0] = ($urandom_range(0, 3) == 0) ? 0.0 : rnd(-0.5, 0.5);
         s[1] = ($urandom_range(0, 3) == 0) ? 0.0 : rnd(-0.5, 0.5);
         zs = ($urandom_range(0, 1) == 0) ? 1.0 : -1.0;
         s[2] = zs * rnd(0.5, 2.0);
         pick = $urandom_range(0, 5);
         lim = (pick == 0) ? f(rnd(0.0, 3.0)) : (pick == 1) ? 32'h7F80_0000 : f(1.0e4);
         add_ray(o, s, lim, {18'($urandom), ax}, 0);
         nf = $urandom_range(1, 10);
         for (int n = 0; n < nf; n++) begin
            if (n > 0 && $urandom_range(0, 7) == 0) begin
               b = stim[$];
               b.tag = 24'($urandom);
            end else begin
               for (int k = 0; k < 3; k++)
                  for (int i = 0; i < 3; i++)
                     v[3 * k + i] = o[i] + ((i == kz) ? zs * rnd(0.2, 20.0) : rnd(-6.0, 6.0));
               add_face(v, 24'($urandom), 0);
               b = stim.pop_back();
               if ($urandom_range(0, 19) == 0) b.w[$urandom_range(0, 8)] = $urandom;
            end
            b.last = (n == nf - 1) ? 1'b1 : 1'b0;
            if ($urandom_range(0, 15) == 0) b.last = ~b.last;
            stim.push_back(b);
         end
      end
   endtask

   // random gap, with stretches of back-to-back beats
   function automatic int draw_gap(int idx);
      if ((idx / 64) % 4 == 1) return 0;
      return $urandom_range(0, 9);
   endfunction

   task automatic send_all();
      beat_type b;
      int       gap;
      for (int idx = 0; idx < stim.size(); idx++) begin
         b = stim[idx];
         if (idx == 300) hold_request = 1;
         if (idx == 700) begin
            // drain everything before resuming
            req_tvalid <= 0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         gap = draw_gap(idx);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid <= 1;
         req_tuser <= b.action;
         req_tlast <= b.last;
         req_tdata <= {b.tag, b.w[8], b.w[7], b.w[6], b.w[5], b.w[4], b.w[3],
                       b.w[2], b.w[1], b.w[0]};
         do @(posedge clock); while (!req_tready);
         sb.note_item(b);
         @(negedge clock);
      end
      req_tvalid <= 0;
   endtask

   // receiver side
   initial begin
      int wait_n;
      @(negedge clock);
      forever begin
         wait_n = (($time / 20000) % 3 == 2) ? 0 : $urandom_range(0, 9);
         if (hold_request) begin
            hold_request = 0;
            wait_n = LONG_HOLD;
         end
         if (wait_n > 0) begin
            rsp_tready <= 0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      build_directed();
      build_random(1250);
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_all();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== closest_ray_triangle_hit.f =====
design/crth_pkg.sv
design/crth_fpu.sv
design/closest_ray_triangle_hit.sv
test/testbench.sv
